>>> hdl/hce_pkg.sv
// Shared types and constants for the variable-length code encoder.
// No dependencies; imported by hce_packer and huffman_code_encoder_top.
package hce_pkg;

    localparam int CODE_W = 32;  // code word field width
    localparam int LEN_W  = 6;   // code length field width
    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        K_LOAD   = 2'd0,
        K_ENCODE = 2'd1,
        K_FINISH = 2'd2,
        K_UNUSED = 2'd3
    } t_kind;

    // Item handed from the lookup stage to the packer.
    typedef struct packed {
        logic              vld;
        t_kind             kind;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_hce_item;

    // One emitted byte with its flags.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_pad;
        logic              last;
    } t_hce_byte;

endpackage

>>> hdl/hce_packer.sv
// Bit accumulator and MSB-first byte packer with a registered output stage.
// Depends on hce_pkg for the item and byte structs.
module hce_packer #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hce_pkg::t_hce_item i_item,
    output logic               o_take,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output hce_pkg::t_hce_byte o_out
);
    import hce_pkg::*;

    localparam int ACC_W = MAX_CODE_LEN + BYTE_W;
    localparam int CNT_W = $clog2(MAX_CODE_LEN + BYTE_W + 1);

    typedef enum logic [1:0] {
        P_TAKE,
        P_BYTES,
        P_FIN_DATA,
        P_FIN_PAD
    } t_pstate;

    t_pstate           r_state;
    logic [ACC_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_vld;
    t_hce_byte         r_out;

    logic [ACC_W-1:0]  n_acc;
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  byte_shift;
    logic [BYTE_W-1:0] top_byte;
    logic [3:0]        pad;
    logic [BYTE_W-1:0] fin_byte;
    logic              out_free;
    logic              emit;

    assign out_free   = !r_out_vld || i_out_ready;
    // Every state other than P_TAKE loads one byte into the output register.
    assign emit       = out_free && (r_state != P_TAKE);
    assign o_take     = (r_state == P_TAKE);
    assign n_acc      = (r_acc << i_item.len) | ACC_W'(i_item.code);
    assign n_cnt      = r_cnt + CNT_W'(i_item.len);
    assign byte_shift = r_cnt - CNT_W'(BYTE_W);
    assign top_byte   = BYTE_W'(r_acc >> byte_shift);
    // At a finish at most 8 bits are pending.
    assign pad        = 4'(BYTE_W) - 4'(r_cnt);
    assign fin_byte   = r_acc[BYTE_W-1:0] << pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= P_TAKE;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                P_TAKE: begin
                    if (i_item.vld) begin
                        unique case (i_item.kind)
                            K_ENCODE: begin
                                if (i_item.len != '0) begin
                                    r_acc <= n_acc;
                                    r_cnt <= n_cnt;
                                    if (n_cnt > CNT_W'(BYTE_W)) begin
                                        r_state <= P_BYTES;
                                    end
                                end
                            end
                            K_FINISH: begin
                                r_state <= P_FIN_DATA;
                            end
                            K_LOAD, K_UNUSED: begin
                            end
                        endcase
                    end
                end
                P_BYTES: begin
                    if (out_free) begin
                        r_out.data   <= top_byte;
                        r_out.is_pad <= 1'b0;
                        r_out.last   <= (r_cnt <= CNT_W'(2 * BYTE_W));
                        r_cnt        <= byte_shift;
                        if (r_cnt <= CNT_W'(2 * BYTE_W)) begin
                            r_state <= P_TAKE;
                        end
                    end
                end
                P_FIN_DATA: begin
                    if (out_free) begin
                        r_out.data   <= fin_byte;
                        r_out.is_pad <= 1'b0;
                        r_out.last   <= 1'b0;
                        r_state      <= P_FIN_PAD;
                    end
                end
                P_FIN_PAD: begin
                    if (out_free) begin
                        r_out.data   <= BYTE_W'(pad);
                        r_out.is_pad <= 1'b1;
                        r_out.last   <= 1'b1;
                        r_acc        <= '0;
                        r_cnt        <= '0;
                        r_state      <= P_TAKE;
                    end
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

>>> hdl/huffman_code_encoder_top.sv
// Top level of the variable-length code encoder: code table memory and lookup stage.
// Depends on hce_pkg and instantiates hce_packer.
//
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tdata: symbol, code_bits, code_length
//                                                      tuser: kind
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata: data_byte
//                                                      tuser: is_pad_count, tlast: last
//
// A load item only writes the code table. An encode item is first merged into the
// accumulator in the packer, which then releases its bytes, up to four at the default
// maximum code length; a finish item passes through the take, data and pad states of
// the packer. The packer's one-byte-per-cycle output sets the rate while the receiver
// is ready. Reset is synchronous and clears the table valid bits, the accumulator and
// all handshake state; no clearing pass is needed. A stalled output holds the packer,
// and the lookup stage keeps accepting until it holds one waiting item.
module huffman_code_encoder_top #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, from bit 0 up: symbol[7:0], code_bits[39:8], code_length[45:40], zeros.
    input  logic [47:0] s_axis_tdata,
    // tuser: kind[1:0].
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: data_byte[7:0].
    output logic [7:0]  m_axis_tdata,
    // tuser: is_pad_count[0].
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import hce_pkg::*;

    localparam int IDX_W = $clog2(SYMBOL_COUNT);
    localparam int ENT_W = LEN_W + CODE_W;

    // Code table: length in the upper bits, masked code word below.
    logic [ENT_W-1:0]        r_tbl_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_tbl_vld;

    // Lookup stage holding one item for the packer.
    logic              r_s1_vld;
    t_kind             r_s1_kind;
    logic              r_rd_hit;
    logic [ENT_W-1:0]  r_rd_ent;

    t_kind             in_kind;
    logic [7:0]        in_sym;
    logic [CODE_W-1:0] in_code;
    logic [LEN_W-1:0]  in_len;
    logic              accept;
    logic              in_range;
    logic [IDX_W-1:0]  idx;
    logic [LEN_W-1:0]  len_sat;
    logic [63:0]       len_mask;
    logic [CODE_W-1:0] code_masked;
    logic              take;
    t_hce_item         item;
    t_hce_byte         out_byte;

    assign in_kind  = t_kind'(s_axis_tuser);
    assign in_sym   = s_axis_tdata[7:0];
    assign in_code  = s_axis_tdata[39:8];
    assign in_len   = s_axis_tdata[45:40];

    assign s_axis_tready = !r_s1_vld || take;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_range      = ({1'b0, in_sym} < 9'(SYMBOL_COUNT));
    assign idx           = in_sym[IDX_W-1:0];

    // Overlong lengths saturate; code bits above the length are dropped.
    assign len_sat     = (in_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : in_len;
    assign len_mask    = ~({64{1'b1}} << len_sat);
    assign code_masked = in_code & len_mask[CODE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_tbl_vld <= '0;
        end else begin
            if (accept && in_kind != K_LOAD) begin
                r_s1_vld <= 1'b1;
            end else if (take) begin
                r_s1_vld <= 1'b0;
            end
            if (accept && in_kind == K_LOAD && in_range) begin
                r_tbl_vld[idx] <= 1'b1;
            end
        end
    end

    // Write and read both happen at the accepting edge, so an encode always sees
    // every load accepted before it.
    always_ff @(posedge i_clk) begin
        if (accept && in_kind == K_LOAD && in_range) begin
            r_tbl_mem[idx] <= {len_sat, code_masked};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind <= in_kind;
            r_rd_hit  <= in_range && r_tbl_vld[idx];
            r_rd_ent  <= r_tbl_mem[idx];
        end
    end

    // Entries never loaded and out-of-range symbols encode as length zero.
    always_comb begin
        item.vld  = r_s1_vld;
        item.kind = r_s1_kind;
        item.len  = r_rd_hit ? r_rd_ent[ENT_W-1:CODE_W] : '0;
        item.code = r_rd_hit ? r_rd_ent[CODE_W-1:0] : '0;
    end

    hce_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .o_take      (take),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out       (out_byte)
    );

    assign m_axis_tdata    = out_byte.data;
    assign m_axis_tuser[0] = out_byte.is_pad;
    assign m_axis_tlast    = out_byte.last;

endmodule

>>> tb/huffman_code_encoder_top_test.sv
// Self-checking testbench for huffman_code_encoder_top: code table loads, symbol encodes
// and stream finishes, with packed bytes checked against a built-in predictor.
// Depends on hce_pkg and the encoder RTL; needs nothing else.
module huffman_code_encoder_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hce_pkg::*;

    localparam int N_SYMBOLS    = 256;
    localparam int CODE_LEN_MAX = 32;
    localparam int RANDOM_ITEMS = 150;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 200000;

    // One input item as the sender holds it before packing it onto the bus.
    typedef struct {
        t_kind       kind;
        logic [7:0]  symbol;
        logic [31:0] code_bits;
        logic [5:0]  code_length;
    } t_enc_item;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = K_LOAD;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    huffman_code_encoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Items waiting to be driven, and the bytes the encoder still owes us.
    t_enc_item  item_q[$];
    t_hce_byte  byte_q[$];

    // Predictor state: the code table and the bit accumulator.
    logic [31:0] pred_code[N_SYMBOLS];
    logic [5:0]  pred_len[N_SYMBOLS];
    logic [63:0] pred_acc;
    int          pred_cnt;

    // Generator bookkeeping: lengths the stimulus has loaded, and symbols with a code.
    int          gen_len[N_SYMBOLS];
    logic [7:0]  coded_syms[$];

    int          err_cnt     = 0;
    int          cycle_cnt   = 0;
    int          total_items = 0;
    int          accepted    = 0;
    bit          src_fire    = 1'b0;

    // Queue one item for the driver and remember which symbols now carry a code.
    function automatic void queue_item(t_kind kind, logic [7:0] sym, logic [31:0] code,
                                       logic [5:0] len);
        t_enc_item it;
        it.kind        = kind;
        it.symbol      = sym;
        it.code_bits   = code;
        it.code_length = len;
        item_q.insert(item_q.size(), it);
        if (kind == K_LOAD) begin
            gen_len[sym] = (len > CODE_LEN_MAX) ? CODE_LEN_MAX : int'(len);
            if (gen_len[sym] != 0)
                coded_syms.insert(coded_syms.size(), sym);
        end
    endfunction

    // Work out the bytes that one accepted item releases and queue them in order.
    task automatic predict_bytes(t_enc_item it);
        t_hce_byte b;
        int        len;
        int        pad;
        int        first;
        case (it.kind)
            K_LOAD: begin
                // Lengths above the maximum saturate; word bits above the length drop.
                len = (it.code_length > CODE_LEN_MAX) ? CODE_LEN_MAX : int'(it.code_length);
                pred_len[it.symbol]  = len[5:0];
                pred_code[it.symbol] = (len >= 32) ? it.code_bits
                                                   : (it.code_bits & ((32'd1 << len) - 1));
            end
            K_ENCODE: begin
                len = int'(pred_len[it.symbol]);
                if (len != 0) begin
                    first    = byte_q.size();
                    pred_acc = (pred_acc << len) | 64'(pred_code[it.symbol]);
                    pred_cnt = pred_cnt + len;
                    // At most 8 bits stay behind after an encode.
                    while (pred_cnt > 8) begin
                        b.data   = 8'(pred_acc >> (pred_cnt - 8));
                        b.is_pad = 1'b0;
                        b.last   = 1'b0;
                        byte_q.insert(byte_q.size(), b);
                        pred_cnt = pred_cnt - 8;
                        pred_acc = pred_acc & ((64'd1 << pred_cnt) - 1);
                    end
                    if (byte_q.size() > first)
                        byte_q[byte_q.size() - 1].last = 1'b1;
                end
            end
            K_FINISH: begin
                // Remaining bits go out left-aligned, then the pad count.
                pad      = 8 - pred_cnt;
                b.data   = 8'(pred_acc << pad);
                b.is_pad = 1'b0;
                b.last   = 1'b0;
                byte_q.insert(byte_q.size(), b);
                b.data   = 8'(pad);
                b.is_pad = 1'b1;
                b.last   = 1'b1;
                byte_q.insert(byte_q.size(), b);
                pred_acc = '0;
                pred_cnt = 0;
            end
            default: ;  // the unused kind is dropped by the block
        endcase
    endtask

    // Sampling side: predict on every accepted input item, then check every
    // accepted output item against the oldest expected byte. Both happen in one
    // block so that a prediction is always queued before it can be compared.
    always @(posedge i_clk) begin
        t_enc_item it;
        t_hce_byte want;
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("huffman_code_encoder_top_test: FAIL");
            $finish;
        end else if (i_rst_n) begin
            src_fire = s_axis_tvalid && s_axis_tready;
            if (src_fire) begin
                it.kind        = t_kind'(s_axis_tuser);
                it.symbol      = s_axis_tdata[7:0];
                it.code_bits   = s_axis_tdata[39:8];
                it.code_length = s_axis_tdata[45:40];
                predict_bytes(it);
                accepted = accepted + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (byte_q.size() == 0) begin
                    $error("unexpected output byte 0x%02h", m_axis_tdata);
                    err_cnt = err_cnt + 1;
                end else begin
                    want = byte_q.pop_front();
                    if (m_axis_tdata !== want.data) begin
                        $error("data_byte: expected 0x%02h, got 0x%02h",
                               want.data, m_axis_tdata);
                        err_cnt = err_cnt + 1;
                    end
                    if (m_axis_tuser[0] !== want.is_pad) begin
                        $error("is_pad_count: expected %0b, got %0b",
                               want.is_pad, m_axis_tuser[0]);
                        err_cnt = err_cnt + 1;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                        err_cnt = err_cnt + 1;
                    end
                end
            end
        end
    end

    // Driving side, on the falling edge. The idle rates follow the share of the
    // stimulus already accepted: a slow sender against a mostly stalled receiver,
    // then the reverse, then both at full speed.
    always @(negedge i_clk) begin
        t_enc_item it;
        int        src_idle;
        int        snk_idle;
        if (accepted < total_items / 3) begin
            src_idle = 36;
            snk_idle = 80;
        end else if (accepted < (2 * total_items) / 3) begin
            src_idle = 80;
            snk_idle = 36;
        end else begin
            src_idle = 0;
            snk_idle = 0;
        end
        if (i_rst_n && (!s_axis_tvalid || src_fire)) begin
            if (item_q.size() != 0 && $urandom_range(99) >= src_idle) begin
                it = item_q.pop_front();
                s_axis_tdata  <= {2'b00, it.code_length, it.code_bits, it.symbol};
                s_axis_tuser  <= it.kind;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end

    initial begin
        int          counted;
        int          r;
        logic [7:0]  sym;
        logic [5:0]  len;

        for (int i = 0; i < N_SYMBOLS; i++) begin
            pred_code[i] = '0;
            pred_len[i]  = '0;
            gen_len[i]   = 0;
        end
        pred_acc = '0;
        pred_cnt = 0;

        // Directed part. Encoding from an empty table gives nothing, and a finish
        // with nothing pending gives a zero byte with a pad count of 8.
        queue_item(K_ENCODE, 8'h00, 32'h0, 6'd0);
        queue_item(K_FINISH, 8'h00, 32'h0, 6'd0);
        queue_item(K_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32);
        // Word bits above the length are dropped, so this code is a single 1.
        queue_item(K_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd1);
        // Lengths beyond the maximum saturate, both at the top of the field and just over.
        queue_item(K_LOAD,   8'h55, 32'hA5A5_A5A5, 6'd63);
        queue_item(K_LOAD,   8'h10, 32'h0000_0000, 6'd33);
        // A zero-length entry encodes to nothing.
        queue_item(K_LOAD,   8'hAA, 32'h1234_5678, 6'd0);
        // A 32-bit code releases three bytes and leaves 8 bits, so the finish has pad 0.
        queue_item(K_ENCODE, 8'hFF, 32'h0, 6'd0);
        queue_item(K_FINISH, 8'hFF, 32'h0, 6'd0);
        queue_item(K_ENCODE, 8'hAA, 32'h0, 6'd0);
        // Eight 1-bit codes stay pending; the ninth pushes a byte out.
        for (int i = 0; i < 9; i++)
            queue_item(K_ENCODE, 8'h00, 32'h0, 6'd0);
        // The unused kind is ignored, whatever its fields hold.
        queue_item(K_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        queue_item(K_ENCODE, 8'h55, 32'h0, 6'd0);
        queue_item(K_ENCODE, 8'h10, 32'h0, 6'd0);
        queue_item(K_FINISH, 8'h00, 32'h0, 6'd0);

        // Random part: mostly encodes of symbols that hold a code, with loads mixed
        // in, finishes now and then, and a little noise from random symbols and the
        // unused kind. Lengths are mostly short so that bytes come often.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 12 || coded_syms.size() == 0) begin
                sym = 8'($urandom_range(255));
                len = ($urandom_range(4) == 0) ? 6'($urandom_range(63))
                                               : 6'($urandom_range(12, 1));
                queue_item(K_LOAD, sym, $urandom, len);
                counted = counted + 1;
            end else if (r < 84) begin
                sym = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                               : coded_syms[$urandom_range(coded_syms.size() - 1)];
                queue_item(K_ENCODE, sym, $urandom, 6'($urandom_range(63)));
                if (gen_len[sym] != 0)
                    counted = counted + 1;
            end else if (r < 95) begin
                queue_item(K_FINISH, 8'($urandom_range(255)), $urandom, 6'($urandom_range(63)));
                counted = counted + 1;
            end else begin
                queue_item(K_UNUSED, 8'($urandom_range(255)), $urandom, 6'($urandom_range(63)));
            end
        end
        // Flush whatever the random part left in the accumulator.
        queue_item(K_FINISH, 8'h00, 32'h0, 6'd0);
        total_items = item_q.size();

        // Synchronous reset, held low from time zero and released at a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every item is on its way in, then until every byte is back,
        // then let the block run on for a drain period to show any stray output.
        while (item_q.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (byte_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && byte_q.size() == 0) begin
            $display("huffman_code_encoder_top_test: PASS");
        end else begin
            $display("huffman_code_encoder_top_test: FAIL");
        end
        $finish;
    end

endmodule
